// ----- rtl/core/srg_pkg.sv -----
// Shared types and constants of the subtractive random generator.
package srg_pkg;

    localparam int LAG_LEN = 55;
    localparam int ADDR_W  = $clog2(LAG_LEN);
    localparam int PTR_W   = 6;
    localparam int WORD_W  = 32;

    localparam logic [WORD_W-1:0] MOD_BIG   = 32'd1000000000;
    localparam logic [WORD_W-1:0] SEED_BASE = 32'd161803398;
    // mj at or below this (as a 33-bit signed value) needs one +1e9 fix-up
    localparam logic signed [WORD_W:0] MJ_LIMIT = -33'sd1000000000;

    localparam logic [ADDR_W-1:0] ADDR_LAST  = ADDR_W'(LAG_LEN - 1);
    localparam logic [ADDR_W-1:0] WARM_OTHER = 6'd31;
    localparam logic [ADDR_W-1:0] SEED_STEP  = 6'd21;
    localparam logic [ADDR_W:0]   POS_WRAP   = 7'd55;
    localparam logic [ADDR_W-1:0] CHAIN_LAST = 6'd53;
    localparam logic [1:0]        PASS_LAST  = 2'd3;

    localparam logic [PTR_W-1:0] PTR_MAX         = 6'd55;
    localparam logic [PTR_W-1:0] PTR_SEED_FIRST  = 6'd0;
    localparam logic [PTR_W-1:0] PTR_SEED_SECOND = 6'd31;
    localparam logic [PTR_W-1:0] IDX_FIRST_PTR   = 6'd55;
    localparam logic [PTR_W-1:0] IDX_SECOND_PTR  = 6'd56;

    typedef enum logic [1:0] {
        FUNC_SEED  = 2'd0,
        FUNC_DRAW  = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_WRITE = 2'd3
    } srg_func_t;

    typedef struct packed {
        logic load;
        logic seed_abs;
        logic seed_mj;
        logic seed_chain;
        logic warm_rd;
        logic warm_wr;
        logic seed_end;
        logic draw_rd;
        logic draw_wr;
        logic stat_rd;
        logic stat_out;
        logic stat_wr;
    } srg_cmd_t;

    typedef struct packed {
        logic chain_last;
        logic warm_last;
    } srg_stat_t;

endpackage

// ----- rtl/core/subtractive_random_generator_top.sv -----
// Top level of the subtractive random generator (ran3 lag table, 55 words).
//
//  channel | dir | tdata (low bit up)                       | tuser
//  --------+-----+------------------------------------------+-------------
//  s_      | in  | seed[31:0], index[37:32], word[69:38]    | func[1:0]
//  m_      | out | value[31:0]                              | error[0]
//
// One command beat in, one result beat out. A beat is taken in the cycle the
// block sits idle; draw and status read pass through a registered read of the
// lag table, then write-back or result, and status write goes straight to its write.
// Seeding runs 54 chain writes and 4 warm-up passes of 55 words,
// each word a table read, then subtract and write, plus accept,
// magnitude, mj write, pointer setup and hand-off.
// Reset marks every table word unwritten (reads back as zero); no clearing pass.
// A result waiting on m_tready does not block the next beat's work; only the
// hand-off into the output register waits.
module subtractive_random_generator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // seed[31:0], index[37:32], word[69:38], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // value[31:0]
    output logic [0:0]  m_tuser    // error[0]
);

    srg_pkg::srg_cmd_t  cmd;
    srg_pkg::srg_stat_t stat;

    logic        out_load;
    logic        out_free;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        m_error_reg;
    logic [31:0] result_value;
    logic        result_error;

    // output slot is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    srg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (srg_pkg::srg_func_t'(s_tuser)),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .out_load (out_load)
    );

    srg_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .item_seed    (s_tdata[31:0]),
        .item_index   (s_tdata[37:32]),
        .item_word    (s_tdata[69:38]),
        .stat         (stat),
        .result_value (result_value),
        .result_error (result_error)
    );

    // output register: load a finished result, drop valid once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= result_value;
            m_error_reg <= result_error;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_error_reg;

endmodule

// ----- rtl/core/srg_ctrl.sv -----
// Controller state machine of the subtractive random generator.
module srg_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  srg_pkg::srg_func_t  func,
    input  logic                out_free,
    input  srg_pkg::srg_stat_t  stat,
    output srg_pkg::srg_cmd_t   cmd,
    output logic                out_load
);

    typedef enum logic [12:0] {
        ST_IDLE       = 13'b0000000000001,
        ST_SEED_ABS   = 13'b0000000000010,
        ST_SEED_MJ    = 13'b0000000000100,
        ST_SEED_CHAIN = 13'b0000000001000,
        ST_WARM_RD    = 13'b0000000010000,
        ST_WARM_WR    = 13'b0000000100000,
        ST_SEED_END   = 13'b0000001000000,
        ST_DRAW_RD    = 13'b0000010000000,
        ST_DRAW_WR    = 13'b0000100000000,
        ST_STAT_RD    = 13'b0001000000000,
        ST_STAT_OUT   = 13'b0010000000000,
        ST_STAT_WR    = 13'b0100000000000,
        ST_FINISH     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    unique case (func)
                        srg_pkg::FUNC_SEED:  state_next = ST_SEED_ABS;
                        srg_pkg::FUNC_DRAW:  state_next = ST_DRAW_RD;
                        srg_pkg::FUNC_READ:  state_next = ST_STAT_RD;
                        srg_pkg::FUNC_WRITE: state_next = ST_STAT_WR;
                        default:             state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEED_ABS: begin
                cmd.seed_abs = 1'b1;
                state_next   = ST_SEED_MJ;
            end
            ST_SEED_MJ: begin
                cmd.seed_mj = 1'b1;
                state_next  = ST_SEED_CHAIN;
            end
            ST_SEED_CHAIN: begin
                cmd.seed_chain = 1'b1;
                if (stat.chain_last) begin
                    state_next = ST_WARM_RD;
                end
            end
            ST_WARM_RD: begin
                cmd.warm_rd = 1'b1;
                state_next  = ST_WARM_WR;
            end
            ST_WARM_WR: begin
                cmd.warm_wr = 1'b1;
                state_next  = stat.warm_last ? ST_SEED_END : ST_WARM_RD;
            end
            ST_SEED_END: begin
                cmd.seed_end = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_DRAW_RD: begin
                cmd.draw_rd = 1'b1;
                state_next  = ST_DRAW_WR;
            end
            ST_DRAW_WR: begin
                cmd.draw_wr = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_STAT_RD: begin
                cmd.stat_rd = 1'b1;
                state_next  = ST_STAT_OUT;
            end
            ST_STAT_OUT: begin
                cmd.stat_out = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_STAT_WR: begin
                cmd.stat_wr = 1'b1;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/srg_dp.sv -----
// Datapath of the subtractive random generator: lag table, pointers, arithmetic.
module srg_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  srg_pkg::srg_cmd_t             cmd,
    input  logic [srg_pkg::WORD_W-1:0]    item_seed,
    input  logic [srg_pkg::PTR_W-1:0]     item_index,
    input  logic [srg_pkg::WORD_W-1:0]    item_word,
    output srg_pkg::srg_stat_t            stat,
    output logic [srg_pkg::WORD_W-1:0]    result_value,
    output logic                          result_error
);

    localparam int AW = srg_pkg::ADDR_W;
    localparam int DW = srg_pkg::WORD_W;
    localparam int PW = srg_pkg::PTR_W;

    // a - b, plus 1e9 when the full-width difference is negative, wrapped to 32 bits
    function automatic logic [DW-1:0] sub_mod(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] d;
        d = {a[DW-1], a} - {b[DW-1], b};
        return d[DW] ? (a - b + srg_pkg::MOD_BIG) : (a - b);
    endfunction

    // lag table and its written-since-reset marks
    logic [DW-1:0]              mem [srg_pkg::LAG_LEN];
    logic [srg_pkg::LAG_LEN-1:0] valid_reg;

    logic [DW-1:0] seed_reg, word_reg;
    logic [PW-1:0] index_reg;
    logic [DW-1:0] mag_reg, mag_next;
    logic [DW-1:0] mj_reg, mj_next, mk_reg, mk_next;
    logic [AW-1:0] pos_reg, pos_next, cnt_reg, cnt_next;
    logic [AW-1:0] warm_idx_reg, warm_idx_next, warm_oth_reg, warm_oth_next;
    logic [1:0]    pass_reg, pass_next;
    logic [PW-1:0] fp_reg, fp_next, sp_reg, sp_next;
    logic [DW-1:0] res_val_reg, res_val_next;
    logic          res_err_reg, res_err_next;

    logic [DW-1:0] rd_a_raw_reg, rd_b_raw_reg;
    logic          rd_a_vld_reg, rd_b_vld_reg;
    logic [DW-1:0] rd_a, rd_b, diff;

    logic [AW-1:0] addr_a, addr_b, wr_addr;
    logic [DW-1:0] wr_data;
    logic          wr_en;

    logic signed [DW:0] mj_raw, mj_fix;
    logic [AW:0]        pos_sum;
    logic [PW-1:0]      fp_adv, sp_adv;
    logic               idx_in_table, word_is_ptr;

    assign rd_a = rd_a_vld_reg ? rd_a_raw_reg : '0;
    assign rd_b = rd_b_vld_reg ? rd_b_raw_reg : '0;
    assign diff = sub_mod(rd_a, rd_b);

    // mj = SEED_BASE - |seed|, C remainder by 1e9 (only a large negative needs fixing)
    assign mj_raw = $signed({1'b0, srg_pkg::SEED_BASE}) - $signed({1'b0, mag_reg});
    assign mj_fix = (mj_raw <= srg_pkg::MJ_LIMIT) ?
                    mj_raw + $signed({1'b0, srg_pkg::MOD_BIG}) : mj_raw;

    assign pos_sum = {1'b0, pos_reg} + {1'b0, srg_pkg::SEED_STEP};
    assign fp_adv  = (fp_reg == srg_pkg::PTR_MAX) ? PW'(1) : fp_reg + PW'(1);
    assign sp_adv  = (sp_reg == srg_pkg::PTR_MAX) ? PW'(1) : sp_reg + PW'(1);

    assign idx_in_table = (index_reg < PW'(srg_pkg::LAG_LEN));
    assign word_is_ptr  = !word_reg[DW-1] && (word_reg <= DW'(srg_pkg::PTR_MAX));

    // read address selection
    always_comb begin
        addr_a = '0;
        addr_b = '0;
        if (cmd.warm_rd) begin
            addr_a = warm_idx_reg;
            addr_b = warm_oth_reg;
        end else if (cmd.draw_rd) begin
            addr_a = AW'(fp_adv - PW'(1));
            addr_b = AW'(sp_adv - PW'(1));
        end else if (cmd.stat_rd && idx_in_table) begin
            addr_a = AW'(index_reg);
        end
    end

    // single write port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (cmd.seed_mj) begin
            wr_en   = 1'b1;
            wr_addr = srg_pkg::ADDR_LAST;
            wr_data = mj_fix[DW-1:0];
        end else if (cmd.seed_chain) begin
            wr_en   = 1'b1;
            wr_addr = pos_reg - AW'(1);
            wr_data = mk_reg;
        end else if (cmd.warm_wr) begin
            wr_en   = 1'b1;
            wr_addr = warm_idx_reg;
            wr_data = diff;
        end else if (cmd.draw_wr) begin
            wr_en   = 1'b1;
            wr_addr = AW'(fp_reg - PW'(1));
            wr_data = diff;
        end else if (cmd.stat_wr && idx_in_table) begin
            wr_en   = 1'b1;
            wr_addr = AW'(index_reg);
            wr_data = word_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_raw_reg <= mem[addr_a];
        rd_b_raw_reg <= mem[addr_b];
        rd_a_vld_reg <= valid_reg[addr_a];
        rd_b_vld_reg <= valid_reg[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // next values of the sequencing and result registers
    always_comb begin
        mag_next      = mag_reg;
        mj_next       = mj_reg;
        mk_next       = mk_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        warm_idx_next = warm_idx_reg;
        warm_oth_next = warm_oth_reg;
        pass_next     = pass_reg;
        fp_next       = fp_reg;
        sp_next       = sp_reg;
        res_val_next  = res_val_reg;
        res_err_next  = res_err_reg;

        if (cmd.seed_abs) begin
            mag_next = seed_reg[DW-1] ? (~seed_reg + DW'(1)) : seed_reg;
        end
        if (cmd.seed_mj) begin
            mj_next       = mj_fix[DW-1:0];
            mk_next       = DW'(1);
            pos_next      = srg_pkg::SEED_STEP;
            cnt_next      = '0;
            warm_idx_next = '0;
            warm_oth_next = srg_pkg::WARM_OTHER;
            pass_next     = '0;
        end
        if (cmd.seed_chain) begin
            mk_next  = sub_mod(mj_reg, mk_reg);
            mj_next  = mk_reg;
            pos_next = (pos_sum >= srg_pkg::POS_WRAP) ?
                       AW'(pos_sum - srg_pkg::POS_WRAP) : AW'(pos_sum);
            cnt_next = cnt_reg + AW'(1);
        end
        if (cmd.warm_wr) begin
            warm_idx_next = (warm_idx_reg == srg_pkg::ADDR_LAST) ? '0 : warm_idx_reg + AW'(1);
            warm_oth_next = (warm_oth_reg == srg_pkg::ADDR_LAST) ? '0 : warm_oth_reg + AW'(1);
            if (warm_idx_reg == srg_pkg::ADDR_LAST) begin
                pass_next = pass_reg + 2'd1;
            end
        end
        if (cmd.seed_end) begin
            fp_next      = srg_pkg::PTR_SEED_FIRST;
            sp_next      = srg_pkg::PTR_SEED_SECOND;
            res_val_next = '0;
            res_err_next = 1'b0;
        end
        if (cmd.draw_rd) begin
            fp_next = fp_adv;
            sp_next = sp_adv;
        end
        if (cmd.draw_wr) begin
            res_val_next = diff;
            res_err_next = 1'b0;
        end
        if (cmd.stat_out) begin
            res_val_next = '0;
            res_err_next = 1'b0;
            if (idx_in_table) begin
                res_val_next = rd_a;
            end else if (index_reg == srg_pkg::IDX_FIRST_PTR) begin
                res_val_next = DW'(fp_reg);
            end else if (index_reg == srg_pkg::IDX_SECOND_PTR) begin
                res_val_next = DW'(sp_reg);
            end else begin
                res_err_next = 1'b1;
            end
        end
        if (cmd.stat_wr) begin
            res_val_next = '0;
            res_err_next = 1'b0;
            if (index_reg == srg_pkg::IDX_FIRST_PTR || index_reg == srg_pkg::IDX_SECOND_PTR) begin
                if (!word_is_ptr) begin
                    res_err_next = 1'b1;
                end else if (index_reg == srg_pkg::IDX_FIRST_PTR) begin
                    fp_next = PW'(word_reg);
                end else begin
                    sp_next = PW'(word_reg);
                end
            end else if (!idx_in_table) begin
                res_err_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            seed_reg  <= item_seed;
            index_reg <= item_index;
            word_reg  <= item_word;
        end
        mag_reg     <= mag_next;
        mj_reg      <= mj_next;
        mk_reg      <= mk_next;
        res_val_reg <= res_val_next;
        res_err_reg <= res_err_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            cnt_reg      <= '0;
            warm_idx_reg <= '0;
            warm_oth_reg <= '0;
            pass_reg     <= '0;
            fp_reg       <= srg_pkg::PTR_SEED_FIRST;
            sp_reg       <= srg_pkg::PTR_SEED_SECOND;
        end else begin
            pos_reg      <= pos_next;
            cnt_reg      <= cnt_next;
            warm_idx_reg <= warm_idx_next;
            warm_oth_reg <= warm_oth_next;
            pass_reg     <= pass_next;
            fp_reg       <= fp_next;
            sp_reg       <= sp_next;
        end
    end

    assign stat.chain_last = (cnt_reg == srg_pkg::CHAIN_LAST);
    assign stat.warm_last  = (pass_reg == srg_pkg::PASS_LAST) &&
                             (warm_idx_reg == srg_pkg::ADDR_LAST);
    assign result_value    = res_val_reg;
    assign result_error    = res_err_reg;

endmodule

// ----- tb/subtractive_random_generator_top_tb.sv -----
// Testbench for the subtractive random generator: directed table plus random commands.
`timescale 1ns / 100ps

module subtractive_random_generator_top_tb;

    // Command row: the beat to send, plus an optional typed-in expectation
    typedef struct packed {
        srg_pkg::srg_func_t func;
        logic [31:0]        seed;
        logic [5:0]         index;
        logic [31:0]        word;
        logic               typed;
        logic [31:0]        exp_value;
        logic               exp_error;
    } cmd_row_t;

    typedef struct packed {
        logic [31:0] value;
        logic        error;
    } result_t;

    localparam int DIR_ROWS      = 27;
    localparam int TOTAL_ITEMS   = 1950;
    localparam int IDLE_LIMIT    = 4000;
    localparam int PRESSURE_AT   = 300;    // beats in before the long hold-off
    localparam int PRESSURE_HOLD = 400;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CHAIN_STRIDE  = 21;
    localparam int WARM_OFFSET   = 30;
    localparam int WARM_PASSES   = 4;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // Own copy of the generator state
    logic signed [31:0] lag_words [srg_pkg::LAG_LEN];
    logic [5:0]         first_ptr;
    logic [5:0]         second_ptr;

    result_t  pending_results [$];
    cmd_row_t cur_row;
    cmd_row_t directed_rows [DIR_ROWS];
    int       beats_in;
    int       beats_out;
    int       fail_count;
    int       idle_cycles;

    subtractive_random_generator_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Generator model
    // ------------------------------------------------------------------

    // Difference with one +1e9 fix-up when negative, wrapped to 32 bits
    function automatic logic signed [31:0] sub_wrap(input longint a, input longint b);
        longint d;
        d = a - b;
        if (d < 0)
            d += longint'(srg_pkg::MOD_BIG);
        return d[31:0];
    endfunction

    task automatic reseed(input logic [31:0] seed);
        longint s;
        longint mj;
        longint mk;
        int     pos;
        int     other;
        s  = longint'(signed'(seed));
        // magnitude in 64 bits, so the most negative seed becomes 2^31
        mj = longint'(srg_pkg::SEED_BASE) - ((s < 0) ? -s : s);
        mj = mj % longint'(srg_pkg::MOD_BIG);   // truncating, sign follows mj
        lag_words[srg_pkg::LAG_LEN-1] = mj[31:0];
        mj = longint'(lag_words[srg_pkg::LAG_LEN-1]);
        mk = 1;
        // spread the difference chain over the table
        for (int i = 1; i < srg_pkg::LAG_LEN; i++) begin
            pos = (CHAIN_STRIDE * i) % srg_pkg::LAG_LEN;
            lag_words[pos-1] = mk[31:0];
            mk = longint'(sub_wrap(mj, mk));
            mj = longint'(lag_words[pos-1]);
        end
        // warm-up passes
        for (int p = 0; p < WARM_PASSES; p++) begin
            for (int i = 1; i <= srg_pkg::LAG_LEN; i++) begin
                other = 1 + (i + WARM_OFFSET) % srg_pkg::LAG_LEN;
                lag_words[i-1] = sub_wrap(longint'(lag_words[i-1]),
                                          longint'(lag_words[other-1]));
            end
        end
        first_ptr  = srg_pkg::PTR_SEED_FIRST;
        second_ptr = srg_pkg::PTR_SEED_SECOND;
    endtask

    task automatic next_draw(output logic [31:0] value);
        // pointers wrap from 55 to 1; pointer 0 steps to 1 before use
        first_ptr  = (first_ptr  >= srg_pkg::PTR_MAX) ? 6'd1 : first_ptr  + 6'd1;
        second_ptr = (second_ptr >= srg_pkg::PTR_MAX) ? 6'd1 : second_ptr + 6'd1;
        lag_words[first_ptr-1] = sub_wrap(longint'(lag_words[first_ptr-1]),
                                          longint'(lag_words[second_ptr-1]));
        value = lag_words[first_ptr-1];
    endtask

    task automatic generator_step(input cmd_row_t c, output result_t r);
        r = '0;
        case (c.func)
            srg_pkg::FUNC_SEED: begin
                reseed(c.seed);
            end
            srg_pkg::FUNC_DRAW: begin
                next_draw(r.value);
            end
            srg_pkg::FUNC_READ: begin
                if (c.index < srg_pkg::LAG_LEN)
                    r.value = lag_words[c.index];
                else if (c.index == srg_pkg::IDX_FIRST_PTR)
                    r.value = 32'(first_ptr);
                else if (c.index == srg_pkg::IDX_SECOND_PTR)
                    r.value = 32'(second_ptr);
                else
                    r.error = 1'b1;
            end
            srg_pkg::FUNC_WRITE: begin
                if (c.index < srg_pkg::LAG_LEN)
                    lag_words[c.index] = c.word;
                else if (c.index == srg_pkg::IDX_FIRST_PTR &&
                         c.word <= 32'(srg_pkg::PTR_MAX))
                    first_ptr = c.word[5:0];
                else if (c.index == srg_pkg::IDX_SECOND_PTR &&
                         c.word <= 32'(srg_pkg::PTR_MAX))
                    second_ptr = c.word[5:0];
                else
                    r.error = 1'b1;
            end
            default: r.error = 1'b1;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Gap length for either side: mostly none or short, a few long;
    // every fifth stretch of 150 beats runs with no idling at all
    function automatic int pick_gap();
        int r;
        if ((beats_in / 150) % 5 == 2)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Mostly draws after a seed, with status traffic and bad accesses as noise
    function automatic cmd_row_t random_command();
        cmd_row_t c;
        int       pick;
        int       sel;
        c       = '0;
        c.seed  = $urandom;
        c.index = 6'($urandom);
        c.word  = $urandom;
        pick    = $urandom_range(0, 99);
        if (pick < 4) begin
            c.func = srg_pkg::FUNC_SEED;
            sel = $urandom_range(0, 2);
            if (sel == 1) begin
                // around the base: mj crosses zero
                c.seed = srg_pkg::SEED_BASE + 32'($urandom_range(0, 2000)) - 32'd1000;
            end else if (sel == 2) begin
                c.seed = 32'($urandom_range(0, 1000));
                if ($urandom_range(0, 1) == 1)
                    c.seed = -c.seed;
            end
        end else if (pick < 70) begin
            c.func = srg_pkg::FUNC_DRAW;
        end else if (pick < 82) begin
            c.func  = srg_pkg::FUNC_READ;
            c.index = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(57, 63))
                                                 : 6'($urandom_range(0, 56));
        end else begin
            c.func = srg_pkg::FUNC_WRITE;
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                c.index = 6'($urandom_range(0, srg_pkg::LAG_LEN - 1));
                if ($urandom_range(0, 1) == 0)
                    c.word = $urandom_range(0, 999999999);
            end else if (sel < 9) begin
                c.index = srg_pkg::IDX_FIRST_PTR + 6'($urandom_range(0, 1));
                if ($urandom_range(0, 4) != 0)
                    c.word = $urandom_range(0, 55);
            end else begin
                c.index = 6'($urandom_range(57, 63));
            end
        end
        return c;
    endfunction

    // Offer one beat (after a random gap) and hold it until taken.
    // Called and returns at a falling edge.
    task automatic send_beat(input cmd_row_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        cur_row  = c;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, c.word, c.index, c.seed};
        s_tuser  <= c.func;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Accept monitor and result checker (sampled at the rising edge)
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t predicted;
        result_t expected;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                beats_in++;
                // advance the model even for typed rows so the state stays in step
                generator_step(cur_row, predicted);
                if (cur_row.typed)
                    pending_results.push_back({cur_row.exp_value, cur_row.exp_error});
                else
                    pending_results.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: value %0d, error %0d",
                           $signed(m_tdata), m_tuser);
                    fail_count++;
                end else begin
                    expected = pending_results.pop_front();
                    if (m_tdata !== expected.value) begin
                        $error("value mismatch at result %0d: expected %0d, actual %0d",
                               beats_out, $signed(expected.value), $signed(m_tdata));
                        fail_count++;
                    end
                    if (m_tuser[0] !== expected.error) begin
                        $error("error mismatch at result %0d: expected %0d, actual %0d",
                               beats_out, expected.error, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: %0d cycles without a beat, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls, plus one long hold-off to back up the block
    // ------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        int hold_left;
        int gap;
        bit pressure_done;
        stall_left    = 0;
        hold_left     = 0;
        pressure_done = 1'b0;
        m_tready      = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!pressure_done && beats_in >= PRESSURE_AT) begin
                // hold off while the sender keeps offering beats
                hold_left     = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    stall_left = gap - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        beats_in    = 0;
        beats_out   = 0;
        fail_count  = 0;
        idle_cycles = 0;
        cur_row     = '0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = srg_pkg::FUNC_SEED;

        // model state after reset
        for (int i = 0; i < srg_pkg::LAG_LEN; i++)
            lag_words[i] = '0;
        first_ptr  = srg_pkg::PTR_SEED_FIRST;
        second_ptr = srg_pkg::PTR_SEED_SECOND;

        // func, seed, index, word, typed, expected value, expected error
        directed_rows = '{
            // status after reset
            '{srg_pkg::FUNC_READ, 32'd0, 6'd0, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_READ, 32'd0, 6'd54, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_READ, 32'd0, srg_pkg::IDX_FIRST_PTR, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_READ, 32'd0, srg_pkg::IDX_SECOND_PTR, 32'd0, 1'b1, 32'd31, 1'b0},
            // index out of range, bad pointer values
            '{srg_pkg::FUNC_READ, 32'd0, 6'd57, 32'd0, 1'b1, 32'd0, 1'b1},
            '{srg_pkg::FUNC_READ, 32'd0, 6'd63, 32'd0, 1'b1, 32'd0, 1'b1},
            '{srg_pkg::FUNC_WRITE, 32'd0, 6'd63, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1},
            '{srg_pkg::FUNC_WRITE, 32'd0, srg_pkg::IDX_FIRST_PTR, 32'd56, 1'b1, 32'd0, 1'b1},
            '{srg_pkg::FUNC_WRITE, 32'd0, srg_pkg::IDX_SECOND_PTR, 32'h8000_0000,
              1'b1, 32'd0, 1'b1},
            // draw with first pointer at 0, on an all-zero table
            '{srg_pkg::FUNC_DRAW, 32'd0, 6'd0, 32'd0, 1'b1, 32'd0, 1'b0},
            // extreme words: the draw difference overflows 32 bits
            '{srg_pkg::FUNC_WRITE, 32'd0, 6'd0, 32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_WRITE, 32'd0, 6'd54, 32'h8000_0000, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_WRITE, 32'd0, srg_pkg::IDX_FIRST_PTR, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_WRITE, 32'd0, srg_pkg::IDX_SECOND_PTR, 32'd54, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_DRAW, 32'd0, 6'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{srg_pkg::FUNC_READ, 32'd0, 6'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{srg_pkg::FUNC_WRITE, 32'd0, srg_pkg::IDX_FIRST_PTR, 32'd55, 1'b1, 32'd0, 1'b0},
            // seeds: zero, largest, most negative, above the base, negative
            '{srg_pkg::FUNC_SEED, 32'd0, 6'd0, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_DRAW, 32'd0, 6'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{srg_pkg::FUNC_SEED, 32'h7FFF_FFFF, 6'd0, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_SEED, 32'h8000_0000, 6'd0, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_DRAW, 32'd0, 6'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{srg_pkg::FUNC_SEED, 32'd161803399, 6'd0, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_DRAW, 32'd0, 6'd0, 32'd0, 1'b0, 32'd0, 1'b0},
            '{srg_pkg::FUNC_SEED, 32'hFFFF_FFFB, 6'd0, 32'd0, 1'b1, 32'd0, 1'b0},
            '{srg_pkg::FUNC_READ, 32'd0, srg_pkg::IDX_SECOND_PTR, 32'd0, 1'b0, 32'd0, 1'b0},
            '{srg_pkg::FUNC_DRAW, 32'd0, 6'd0, 32'd0, 1'b0, 32'd0, 1'b0}
        };

        // hold reset, then release at a falling edge
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_beat(directed_rows[i]);

        for (int n = DIR_ROWS; n < TOTAL_ITEMS; n++)
            send_beat(random_command());
        s_tvalid <= 1'b0;

        // drain; the watchdog covers a hang here
        while (pending_results.size() != 0)
            @(posedge aclk);
        // give any stray result time to show up
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
